FILE: design/swbc_pkg.sv
// swbc_pkg: fixed widths, opcodes, line status codes and age-unit result type
// for the set-associative write-back cache. No dependencies.
package swbc_pkg;

  localparam int ADDR_W = 17;
  localparam int DATA_W = 32;
  localparam int AGE_W  = 32;

  typedef enum logic [0:0] {OP_READ = 1'b0, OP_WRITE = 1'b1} op_t;

  typedef enum logic [1:0] {
    ST_INVALID  = 2'd0,
    ST_VALID    = 2'd1,
    ST_MODIFIED = 2'd2
  } line_status_t;

  // result of one pass through the shared age unit
  typedef struct packed {
    logic             hit;
    logic             take;
    logic [AGE_W-1:0] age;
  } age_res_t;

endpackage

FILE: design/swbc_if.sv
// swbc_in_if / swbc_out_if: valid/ready channels of the cache.
// Depends on swbc_pkg for field widths.
interface swbc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic        [swbc_pkg::ADDR_W-1:0]  word_address;
  logic signed [swbc_pkg::DATA_W-1:0]  write_word;
  modport source (output valid, opcode, word_address, write_word, input ready);
  modport sink   (input valid, opcode, word_address, write_word, output ready);
endinterface

interface swbc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [swbc_pkg::DATA_W-1:0]  read_word;
  logic                                was_hit;
  modport source (output valid, read_word, was_hit, input ready);
  modport sink   (input valid, read_word, was_hit, output ready);
endinterface

FILE: design/set_assoc_writeback_cache.sv
// set_assoc_writeback_cache: 4-way write-back cache, LRU-by-age victim.
// An access reads its set's metadata, scans the ways one by one through the
// shared age unit, then on a hit reads or writes the line memory; a miss (a write
// miss first stores its word to backing memory) fills the victim line word by word.
// Accesses do not overlap; a new beat is taken while the last result waits. Reset
// (rst_n, synchronous) invalidates all sets at once, then clears backing memory.
module set_assoc_writeback_cache #(
  parameter int SETS           = 128,
  parameter int WAYS           = 4,
  parameter int WORDS_PER_LINE = 8,
  parameter int MEM_WORDS      = 131072
) (
  input  logic       clk,
  input  logic       rst_n,
  swbc_in_if.sink    in_ch,
  swbc_out_if.source out_ch
);
  localparam int AW     = swbc_pkg::ADDR_W;
  localparam int DW     = swbc_pkg::DATA_W;
  localparam int GW     = swbc_pkg::AGE_W;
  localparam int OFF_W  = $clog2(WORDS_PER_LINE);
  localparam int SET_W  = $clog2(SETS);
  localparam int WAY_W  = $clog2(WAYS);
  localparam int TAG_W  = AW - OFF_W - SET_W;
  localparam int LM_AW  = SET_W + WAY_W + OFF_W;
  localparam int LM_D   = SETS * WAYS * WORDS_PER_LINE;
  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam int BA_W   = (AW > MEM_AW) ? AW : MEM_AW;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_META  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_HIT   = 9'b000010000,
    S_HITRD = 9'b000100000,
    S_STORE = 9'b001000000,
    S_FRD   = 9'b010000000,
    S_FWR   = 9'b100000000
  } state_t;

  state_t state_r;
  logic                       op_r;
  logic [AW-1:0]              addr_r;
  logic [DW-1:0]              wdata_r;
  logic [DW-1:0]              rdata_r;
  logic                       hit_r;
  logic [WAY_W-1:0]           way_r;
  logic [WAY_W-1:0]           sel_way_r;
  logic [OFF_W-1:0]           idx_r;
  logic [GW-1:0]              best_r;
  logic [MEM_AW-1:0]          clr_r;
  logic                       done_r;
  logic                       out_valid_r;
  logic [DW-1:0]              out_word_r;
  logic                       out_hit_r;
  logic [SETS-1:0]            row_vld_r;

  // set metadata, one row per set
  logic [WAYS-1:0][1:0]       stat_mem [SETS];
  logic [WAYS-1:0][TAG_W-1:0] tag_mem  [SETS];
  logic [WAYS-1:0][GW-1:0]    age_mem  [SETS];
  logic [WAYS-1:0][1:0]       stat_rd_r;
  logic [WAYS-1:0][TAG_W-1:0] tag_rd_r;
  logic [WAYS-1:0][GW-1:0]    age_rd_r;
  logic [WAYS-1:0][1:0]       stat_row_r;
  logic [WAYS-1:0][TAG_W-1:0] tag_row_r;
  logic [WAYS-1:0][GW-1:0]    age_row_r;

  logic [DW-1:0]              line_mem [LM_D];
  logic [DW-1:0]              line_rd_r;

  logic [OFF_W-1:0]           off;
  logic [SET_W-1:0]           set_idx;
  logic [TAG_W-1:0]           tag;
  logic [SET_W-1:0]           in_set;
  logic                       accept;
  logic                       out_free;
  logic                       meta_we;

  swbc_pkg::age_res_t         ares;

  logic                       bk_we, bk_re;
  logic [AW-1:0]              bk_waddr;
  logic [BA_W-1:0]            bk_ext;
  logic [MEM_AW-1:0]          bk_addr;
  logic [DW-1:0]              bk_wdata, bk_rdata;

  logic                       lm_we, lm_re;
  logic [WAY_W-1:0]           lm_way;
  logic [OFF_W-1:0]           lm_off;
  logic [LM_AW-1:0]           lm_addr;
  logic [DW-1:0]              lm_wdata;

  logic                       old_mod;

  assign off     = addr_r[OFF_W-1:0];
  assign set_idx = addr_r[OFF_W +: SET_W];
  assign tag     = addr_r[AW-1 -: TAG_W];
  assign in_set  = in_ch.word_address[OFF_W +: SET_W];

  assign in_ch.ready      = (state_r == S_IDLE) && !done_r;
  assign accept           = in_ch.valid && in_ch.ready;
  assign out_free         = !out_valid_r || out_ch.ready;
  assign meta_we          = done_r && out_free;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_word = out_word_r;
  assign out_ch.was_hit   = out_hit_r;

  assign old_mod = (stat_row_r[sel_way_r] == 2'(swbc_pkg::ST_MODIFIED));

  swbc_age_unit u_age (
    .way_valid (stat_row_r[way_r] != 2'(swbc_pkg::ST_INVALID)),
    .tag_eq    (tag_row_r[way_r] == tag),
    .age       (age_row_r[way_r]),
    .best      (best_r),
    .first     (way_r == '0),
    .res       (ares)
  );

  // backing memory port steering
  always_comb begin
    bk_we    = 1'b0;
    bk_re    = 1'b0;
    bk_waddr = addr_r;
    bk_wdata = wdata_r;
    case (state_r)
      S_CLEAR: begin
        bk_we    = 1'b1;
        bk_wdata = '0;
      end
      S_STORE: bk_we = 1'b1;
      S_FRD: begin
        bk_re    = 1'b1;
        bk_waddr = {tag, set_idx, idx_r};
      end
      S_FWR: begin
        bk_we    = old_mod;
        bk_waddr = {tag_row_r[sel_way_r], set_idx, idx_r};
        bk_wdata = line_rd_r;
      end
      default: ;
    endcase
    bk_ext  = BA_W'(bk_waddr);
    bk_addr = (state_r == S_CLEAR) ? clr_r : bk_ext[MEM_AW-1:0];
  end

  swbc_backing_mem #(.DEPTH(MEM_WORDS), .AW(MEM_AW), .DW(DW)) u_bk (
    .clk   (clk),
    .we    (bk_we),
    .re    (bk_re),
    .addr  (bk_addr),
    .wdata (bk_wdata),
    .rdata (bk_rdata)
  );

  // line memory port steering
  always_comb begin
    lm_we    = 1'b0;
    lm_re    = 1'b0;
    lm_way   = sel_way_r;
    lm_off   = idx_r;
    lm_wdata = bk_rdata;
    case (state_r)
      S_HIT: begin
        lm_off   = off;
        lm_we    = (op_r == swbc_pkg::OP_WRITE);
        lm_re    = (op_r == swbc_pkg::OP_READ);
        lm_wdata = wdata_r;
      end
      S_FRD: lm_re = 1'b1;
      S_FWR: lm_we = 1'b1;
      default: ;
    endcase
    lm_addr = {set_idx, lm_way, lm_off};
  end

  always_ff @(posedge clk) begin
    if (lm_we) begin
      line_mem[lm_addr] <= lm_wdata;
    end else if (lm_re) begin
      line_rd_r <= line_mem[lm_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      stat_mem[set_idx] <= stat_row_r;
      tag_mem[set_idx]  <= tag_row_r;
      age_mem[set_idx]  <= age_row_r;
    end else if (accept) begin
      stat_rd_r <= stat_mem[in_set];
      tag_rd_r  <= tag_mem[in_set];
      age_rd_r  <= age_mem[in_set];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_ch.opcode;
      addr_r  <= in_ch.word_address;
      wdata_r <= in_ch.write_word;
      rdata_r <= '0;
    end
    case (state_r)
      S_META: begin
        if (row_vld_r[set_idx]) begin
          stat_row_r <= stat_rd_r;
          tag_row_r  <= tag_rd_r;
          age_row_r  <= age_rd_r;
        end else begin
          stat_row_r <= '0;
          tag_row_r  <= '0;
          age_row_r  <= '0;
        end
      end
      S_SCAN: begin
        age_row_r[way_r] <= ares.age;
        if (ares.hit) sel_way_r <= way_r;
        if (ares.take && !hit_r) begin
          best_r    <= ares.age;
          sel_way_r <= way_r;
        end
      end
      S_HIT: begin
        if (op_r == swbc_pkg::OP_WRITE) stat_row_r[sel_way_r] <= 2'(swbc_pkg::ST_MODIFIED);
      end
      S_HITRD: rdata_r <= line_rd_r;
      S_FWR: begin
        if (idx_r == off && op_r == swbc_pkg::OP_READ) rdata_r <= bk_rdata;
        if (idx_r == OFF_W'(WORDS_PER_LINE - 1)) begin
          stat_row_r[sel_way_r] <= 2'(swbc_pkg::ST_VALID);
          tag_row_r[sel_way_r]  <= tag;
          age_row_r[sel_way_r]  <= '0;
        end
      end
      default: ;
    endcase
    if (meta_we) begin
      out_word_r <= rdata_r;
      out_hit_r  <= hit_r;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      row_vld_r   <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      way_r       <= '0;
      idx_r       <= '0;
    end else begin
      if (meta_we) begin
        out_valid_r        <= 1'b1;
        done_r             <= 1'b0;
        row_vld_r[set_idx] <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + MEM_AW'(1);
          if (clr_r == MEM_AW'(MEM_WORDS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            hit_r   <= 1'b0;
            state_r <= S_META;
          end
        end
        S_META: begin
          way_r   <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (ares.hit) hit_r <= 1'b1;
          way_r <= way_r + WAY_W'(1);
          if (way_r == WAY_W'(WAYS - 1)) begin
            idx_r <= '0;
            if (hit_r || ares.hit) state_r <= S_HIT;
            else if (op_r == swbc_pkg::OP_WRITE) state_r <= S_STORE;
            else state_r <= S_FRD;
          end
        end
        S_HIT: begin
          if (op_r == swbc_pkg::OP_WRITE) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_HITRD;
          end
        end
        S_HITRD: begin
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        S_STORE: state_r <= S_FRD;
        S_FRD:   state_r <= S_FWR;
        S_FWR: begin
          idx_r <= idx_r + OFF_W'(1);
          if (idx_r == OFF_W'(WORDS_PER_LINE - 1)) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_FRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: design/swbc_age_unit.sv
// swbc_age_unit: shared per-way hit check, saturating age increment and
// victim compare, used once per way during the set scan. Uses swbc_pkg.
module swbc_age_unit (
  input  logic                         way_valid,
  input  logic                         tag_eq,
  input  logic [swbc_pkg::AGE_W-1:0]   age,
  input  logic [swbc_pkg::AGE_W-1:0]   best,
  input  logic                         first,
  output swbc_pkg::age_res_t           res
);
  logic hit;
  logic [swbc_pkg::AGE_W-1:0] age_inc;

  assign hit     = way_valid & tag_eq;
  assign age_inc = (&age) ? age : age + swbc_pkg::AGE_W'(1);

  always_comb begin
    res.hit  = hit;
    res.age  = hit ? '0 : age_inc;
    // strict compare keeps the lowest way on ties
    res.take = !hit && (first || (age_inc > best));
  end
endmodule

FILE: design/swbc_backing_mem.sv
// swbc_backing_mem: single-port backing word memory, registered read.
// No package dependencies.
module swbc_backing_mem #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

FILE: sim/set_assoc_writeback_cache_test.sv
// Testbench for set_assoc_writeback_cache: random and directed word accesses
// checked against an in-bench cache/backing-memory predictor.
// Depends on swbc_pkg, swbc_if and the cache RTL.
`timescale 1ns / 1ps

module set_assoc_writeback_cache_test;

  localparam int SETS = 128;
  localparam int WAYS = 4;
  localparam int WPL  = 8;
  localparam int MEMW = 131072;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic                        opcode;
    logic [swbc_pkg::ADDR_W-1:0] addr;
    logic [swbc_pkg::DATA_W-1:0] wdata;
  } access_t;

  typedef struct packed {
    logic [swbc_pkg::DATA_W-1:0] rdata;
    logic                        hit;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  swbc_in_if  in_ch ();
  swbc_out_if out_ch ();

  set_assoc_writeback_cache u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  // predictor state
  swbc_pkg::line_status_t      p_status [SETS*WAYS];
  logic [6:0]                  p_tag    [SETS*WAYS];
  logic [swbc_pkg::DATA_W-1:0] p_words  [SETS*WAYS*WPL];
  logic [swbc_pkg::AGE_W-1:0]  p_age    [SETS*WAYS];
  logic [swbc_pkg::DATA_W-1:0] p_mem    [MEMW];

  access_t  pending_q [$];
  outcome_t expected_q [$];
  int errors = 0;
  int cycles = 0;
  int hold_cnt = 0;
  bit hold_go = 0;
  bit hold_used = 0;
  bit pause_req = 0;
  int in_gap = 0;
  int out_gap = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic outcome_t cache_access(access_t a);
    outcome_t r;
    int off, tp, set, base, k, victim;
    logic [6:0] tag;
    logic [swbc_pkg::AGE_W-1:0] best;
    swbc_pkg::line_status_t ost;
    logic [6:0] otag;
    logic [swbc_pkg::DATA_W-1:0] old [WPL];
    r = '0;
    off = a.addr % WPL;
    tp = a.addr / WPL;
    set = tp % SETS;
    tag = 7'(tp / SETS);
    base = set * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      k = base + w;
      if (p_status[k] != swbc_pkg::ST_INVALID && p_tag[k] == tag) begin
        r.hit = 1'b1;
        p_age[k] = '0;
        if (a.opcode == swbc_pkg::OP_WRITE) begin
          p_words[k*WPL+off] = a.wdata;
          p_status[k] = swbc_pkg::ST_MODIFIED;
        end else begin
          r.rdata = p_words[k*WPL+off];
        end
      end else if (p_age[k] != '1) begin
        p_age[k] = p_age[k] + swbc_pkg::AGE_W'(1);
      end
    end
    if (!r.hit) begin
      victim = 0;
      best = p_age[base];
      for (int w = 1; w < WAYS; w++)
        if (p_age[base+w] > best) begin
          best = p_age[base+w];
          victim = w;
        end
      k = base + victim;
      ost = p_status[k];
      otag = p_tag[k];
      for (int i = 0; i < WPL; i++) old[i] = p_words[k*WPL+i];
      if (a.opcode == swbc_pkg::OP_WRITE) p_mem[a.addr % MEMW] = a.wdata;
      for (int i = 0; i < WPL; i++) p_words[k*WPL+i] = p_mem[(tp*WPL+i) % MEMW];
      p_tag[k] = tag;
      p_status[k] = swbc_pkg::ST_VALID;
      p_age[k] = '0;
      if (ost == swbc_pkg::ST_MODIFIED)
        for (int i = 0; i < WPL; i++) p_mem[((otag*SETS+set)*WPL+i) % MEMW] = old[i];
      if (a.opcode == swbc_pkg::OP_READ) r.rdata = p_words[k*WPL+off];
    end
    if (a.opcode == swbc_pkg::OP_WRITE) r.rdata = '0;
    return r;
  endfunction

  function automatic access_t mk(swbc_pkg::op_t op, int addr, logic [31:0] d);
    access_t a;
    a.opcode = op;
    a.addr = swbc_pkg::ADDR_W'(addr);
    a.wdata = d;
    return a;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.opcode <= 1'b0;
      in_ch.word_address <= '0;
      in_ch.write_word <= '0;
      in_gap <= 0;
    end else if (in_ch.valid && in_ch.ready) begin
      expected_q.push_back(cache_access(pending_q.pop_front()));
      in_ch.valid <= 1'b0;
      in_gap <= $urandom_range(0, 9);
    end else if (!in_ch.valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_q.size() > 0 && !(pause_req && expected_q.size() > 0)) begin
        in_ch.valid <= 1'b1;
        in_ch.opcode <= pending_q[0].opcode;
        in_ch.word_address <= pending_q[0].addr;
        in_ch.write_word <= pending_q[0].wdata;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_cnt <= 3000;
      hold_used <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      cycles <= cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result beat: %h hit %b",
                                    out_ch.read_word, out_ch.was_hit);
        end else begin
          e = expected_q.pop_front();
          if (e.rdata !== out_ch.read_word || e.hit !== out_ch.was_hit) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: exp %h hit %b, got %h hit %b",
                       e.rdata, e.hit, out_ch.read_word, out_ch.was_hit);
          end
        end
        out_ch.ready <= 1'b0;
        out_gap <= $urandom_range(0, 9);
      end else if (hold_cnt > 0) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int a, n, tg, st;
    for (int i = 0; i < SETS*WAYS; i++) begin
      p_status[i] = swbc_pkg::ST_INVALID;
      p_tag[i] = '0;
      p_age[i] = '0;
    end
    foreach (p_words[i]) p_words[i] = '0;
    foreach (p_mem[i]) p_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, hits, write misses, dirty evictions in one set
    pending_q.push_back(mk(swbc_pkg::OP_READ, 0, 0));
    pending_q.push_back(mk(swbc_pkg::OP_READ, 131071, 0));
    pending_q.push_back(mk(swbc_pkg::OP_WRITE, 131071, 32'h8000_0000));
    pending_q.push_back(mk(swbc_pkg::OP_READ, 131071, 32'hFFFF_FFFF));
    pending_q.push_back(mk(swbc_pkg::OP_WRITE, 0, 32'h7FFF_FFFF));
    pending_q.push_back(mk(swbc_pkg::OP_WRITE, 1, 32'hFFFF_FFFF));
    pending_q.push_back(mk(swbc_pkg::OP_READ, 1, 0));
    for (int t = 1; t <= 6; t++)
      pending_q.push_back(mk(swbc_pkg::OP_WRITE, t*1024 + 3, 32'hA500_0000 + t));
    for (int t = 0; t <= 6; t++) pending_q.push_back(mk(swbc_pkg::OP_READ, t*1024 + 3, 0));
    pending_q.push_back(mk(swbc_pkg::OP_READ, 0, 0));
    pending_q.push_back(mk(swbc_pkg::OP_WRITE, 127*1024 + 1023, 32'h5555_AAAA));
    pending_q.push_back(mk(swbc_pkg::OP_READ, 1023, 0));

    // random: mostly a small pool of tags per few sets so evictions recur
    for (int i = 0; i < 1250; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        st = $urandom_range(0, 3) * 37;
        tg = $urandom_range(0, 7) * 17;
        a = (tg * SETS + st) * WPL + $urandom_range(0, 7);
      end else begin
        a = $urandom_range(0, 131071);
      end
      pending_q.push_back(mk(swbc_pkg::op_t'($urandom_range(0, 1)), a, $urandom()));
    end

    // long receiver hold-off while the sender keeps offering
    wait (pending_q.size() < 1100);
    hold_go = 1;
    // sender pause until all results have drained
    wait (pending_q.size() < 600);
    pause_req = 1;
    @(posedge clk);
    wait (expected_q.size() == 0);
    pause_req = 0;

    n = 0;
    while (n < LIMIT && (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0)) begin
      @(posedge clk);
      n++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0 && pending_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    wait (cycles > LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
